// ===== hw/rtl/fcc_pkg.sv =====
package fcc_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int PLANE_COUNT      = 6;
    localparam int AXIS_COUNT       = 3;

    // packed plane register: four signed 16-bit slots
    localparam int PF_W      = 16;
    localparam int PLANE_W   = 4 * PF_W;
    localparam int CFG_IDX_W = $clog2(PLANE_COUNT);

    localparam int RAD_W  = COORD_WIDTH - 1;
    localparam int PROD_W = PF_W + COORD_WIDTH;
    localparam int D_W    = PF_W + NORMAL_FRAC_BITS;
    localparam int RADS_W = RAD_W + NORMAL_FRAC_BITS;
    localparam int SUM_W  = ((PROD_W > D_W) ? PROD_W : D_W) + 2;
    localparam int CMP_W  = ((SUM_W > RADS_W + 1) ? SUM_W : RADS_W + 1) + 1;

    typedef enum logic [1:0] {
        VIS_OUTSIDE  = 2'd0,
        VIS_CROSSING = 2'd1,
        VIS_INSIDE   = 2'd2
    } t_vis;

    typedef enum logic {
        KIND_SPHERE = 1'b0,
        KIND_BOX    = 1'b1
    } t_kind;

endpackage

// ===== hw/rtl/frustum_cull_classifier.sv =====
// Frustum culling classifier.
// Six planes are loaded through the write port (i_cfg_we, i_cfg_index, i_cfg_data):
// normal x/y/z in bits 47:0 as signed fixed point, plane distance in bits 63:48.
// Write planes only while no request is in flight; indexes above five are ignored.
// Input channel (i_valid / o_stall) takes one sphere or box request per cycle while
// o_stall is low; i_action picks the volume kind. Output channel (o_valid / i_stall) returns one
// o_visibility code per request, in order: outside, intersecting or inside.
// From acceptance to o_valid a request passes the registered stages multiply, per-axis
// min/max, four-term sum, and compare and reduce. Throughput is one request per cycle
// while o_stall is low, set by the 36 parallel multipliers in the first stage.
// A stall from the receiver holds the output register; upstream stages keep
// filling empty slots, and o_stall rises only when every stage holds a request.
// Reset clears all plane registers to zero and empties the pipeline.
module frustum_cull_classifier
    import fcc_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_action,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    input  logic signed [COORD_WIDTH-1:0] i_far_x,
    input  logic signed [COORD_WIDTH-1:0] i_far_y,
    input  logic signed [COORD_WIDTH-1:0] i_far_z,
    input  logic        [RAD_W-1:0]       i_radius,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic        [1:0]             o_visibility,
    input  logic                          i_cfg_we,
    input  logic        [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic        [PLANE_W-1:0]     i_cfg_data
);

    logic [PLANE_W-1:0] r_plane [PLANE_COUNT];

    // stage valids and advance enables
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3, en4;

    // stage 1: products
    logic signed [PROD_W-1:0] r1_lo [PLANE_COUNT][AXIS_COUNT];
    logic signed [PROD_W-1:0] r1_hi [PLANE_COUNT][AXIS_COUNT];
    logic signed [D_W-1:0]    r1_d  [PLANE_COUNT];
    logic        [RADS_W-1:0] r1_rad;
    t_kind                    r1_kind;

    // stage 2: per-axis extremes
    logic signed [PROD_W-1:0] r2_min [PLANE_COUNT][AXIS_COUNT];
    logic signed [PROD_W-1:0] r2_max [PLANE_COUNT][AXIS_COUNT];
    logic signed [D_W-1:0]    r2_d   [PLANE_COUNT];
    logic        [RADS_W-1:0] r2_rad;
    t_kind                    r2_kind;

    // stage 3: nearest / farthest plane distances
    logic signed [SUM_W-1:0]  r3_dmin [PLANE_COUNT];
    logic signed [SUM_W-1:0]  r3_dmax [PLANE_COUNT];
    logic        [RADS_W-1:0] r3_rad;
    t_kind                    r3_kind;

    // stage 4: result
    t_vis r4_vis;

    logic signed [PROD_W-1:0] n1_lo [PLANE_COUNT][AXIS_COUNT];
    logic signed [PROD_W-1:0] n1_hi [PLANE_COUNT][AXIS_COUNT];
    logic signed [D_W-1:0]    n1_d  [PLANE_COUNT];
    logic signed [PROD_W-1:0] n2_min [PLANE_COUNT][AXIS_COUNT];
    logic signed [PROD_W-1:0] n2_max [PLANE_COUNT][AXIS_COUNT];
    logic signed [SUM_W-1:0]  n3_dmin [PLANE_COUNT];
    logic signed [SUM_W-1:0]  n3_dmax [PLANE_COUNT];
    t_vis                     n4_vis;

    logic signed [COORD_WIDTH-1:0] lo_c [AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] hi_c [AXIS_COUNT];

    assign lo_c[0] = i_point_x;
    assign lo_c[1] = i_point_y;
    assign lo_c[2] = i_point_z;
    assign hi_c[0] = i_far_x;
    assign hi_c[1] = i_far_y;
    assign hi_c[2] = i_far_z;

    // a stage moves when it is empty or the next one moves
    assign en4     = !o_valid || !i_stall;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_plane[p] <= '0;
            end
        end else if (i_cfg_we && (int'(i_cfg_index) < PLANE_COUNT)) begin
            r_plane[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) o_valid <= r_v3;
        end
    end

    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                n1_lo[p][a] = PROD_W'($signed(r_plane[p][a*PF_W +: PF_W])) * PROD_W'(lo_c[a]);
                n1_hi[p][a] = PROD_W'($signed(r_plane[p][a*PF_W +: PF_W])) * PROD_W'(hi_c[a]);
            end
            n1_d[p] = D_W'($signed(r_plane[p][3*PF_W +: PF_W])) <<< NORMAL_FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_lo   <= n1_lo;
            r1_hi   <= n1_hi;
            r1_d    <= n1_d;
            r1_rad  <= {i_radius, {NORMAL_FRAC_BITS{1'b0}}};
            r1_kind <= t_kind'(i_action);
        end
    end

    // a box splits each axis term into its nearer and farther corner;
    // a sphere uses the center term for both
    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            for (int a = 0; a < AXIS_COUNT; a++) begin
                if (r1_kind == KIND_BOX) begin
                    if (r1_lo[p][a] < r1_hi[p][a]) begin
                        n2_min[p][a] = r1_lo[p][a];
                        n2_max[p][a] = r1_hi[p][a];
                    end else begin
                        n2_min[p][a] = r1_hi[p][a];
                        n2_max[p][a] = r1_lo[p][a];
                    end
                end else begin
                    n2_min[p][a] = r1_lo[p][a];
                    n2_max[p][a] = r1_lo[p][a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_min  <= n2_min;
            r2_max  <= n2_max;
            r2_d    <= r1_d;
            r2_rad  <= r1_rad;
            r2_kind <= r1_kind;
        end
    end

    always_comb begin
        for (int p = 0; p < PLANE_COUNT; p++) begin
            n3_dmin[p] = SUM_W'(r2_min[p][0]) + SUM_W'(r2_min[p][1])
                       + SUM_W'(r2_min[p][2]) + SUM_W'(r2_d[p]);
            n3_dmax[p] = SUM_W'(r2_max[p][0]) + SUM_W'(r2_max[p][1])
                       + SUM_W'(r2_max[p][2]) + SUM_W'(r2_d[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_dmin <= n3_dmin;
            r3_dmax <= n3_dmax;
            r3_rad  <= r2_rad;
            r3_kind <= r2_kind;
        end
    end

    always_comb begin
        logic signed [CMP_W-1:0] rad_p;
        logic signed [CMP_W-1:0] rad_n;
        logic                    any_out;
        logic                    all_in;
        rad_p   = CMP_W'({1'b0, r3_rad});
        rad_n   = -rad_p;
        any_out = 1'b0;
        all_in  = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            if (r3_kind == KIND_BOX) begin
                // all corners behind: farthest corner negative
                if (r3_dmax[p] < 0) any_out = 1'b1;
                if (r3_dmin[p] < 0) all_in = 1'b0;
            end else begin
                if (CMP_W'(r3_dmin[p]) < rad_n) any_out = 1'b1;
                if (!(CMP_W'(r3_dmin[p]) > rad_p)) all_in = 1'b0;
            end
        end
        if (any_out) begin
            n4_vis = VIS_OUTSIDE;
        end else if (all_in) begin
            n4_vis = VIS_INSIDE;
        end else begin
            n4_vis = VIS_CROSSING;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_vis <= n4_vis;
        end
    end

    assign o_visibility = r4_vis;

    a_vis_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_visibility == VIS_OUTSIDE || o_visibility == VIS_CROSSING
                     || o_visibility == VIS_INSIDE))
        else $error("visibility code out of range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && o_valid && i_stall) |-> o_stall)
        else $error("full stalled pipeline must stall input");

    a_bubble_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 || !r_v2 || !r_v3 || !o_valid || !i_stall) |-> !o_stall)
        else $error("input stalled while a stage is free");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v1)
        else $error("accepted request lost at stage 1");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule

// ===== tb/frustum_cull_classifier_test.sv =====
`timescale 1ns / 1ps

module frustum_cull_classifier_test;
    import fcc_pkg::*;

    localparam int CLK_HALF       = 4;
    localparam int RESET_CYCLES   = 10;
    localparam int PIPE_LATENCY   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 48;
    localparam int RAND_PHASES    = 10;
    localparam int REQS_PER_PHASE = 150;
    localparam int NORM_ONE       = 1 << NORMAL_FRAC_BITS;
    // write indexes past the last plane, must be ignored
    localparam int IDX_SPARE_LO   = PLANE_COUNT;
    localparam int IDX_SPARE_HI   = (1 << CFG_IDX_W) - 1;

    typedef enum int {
        PMODE_FRUSTUM = 0,
        PMODE_RANDOM  = 1,
        PMODE_EXTREME = 2,
        PMODE_MIXED   = 3
    } t_plane_mode;

    typedef struct packed {
        t_kind                         kind;
        logic signed [COORD_WIDTH-1:0] px;
        logic signed [COORD_WIDTH-1:0] py;
        logic signed [COORD_WIDTH-1:0] pz;
        logic signed [COORD_WIDTH-1:0] fx;
        logic signed [COORD_WIDTH-1:0] fy;
        logic signed [COORD_WIDTH-1:0] fz;
        logic [RAD_W-1:0]              radius;
    } t_req;

    typedef struct {
        int   phase;
        t_req req;
        bit   known;
        t_vis vis;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic                   i_action;
    logic [COORD_WIDTH-1:0] i_point_x;
    logic [COORD_WIDTH-1:0] i_point_y;
    logic [COORD_WIDTH-1:0] i_point_z;
    logic [COORD_WIDTH-1:0] i_far_x;
    logic [COORD_WIDTH-1:0] i_far_y;
    logic [COORD_WIDTH-1:0] i_far_z;
    logic [RAD_W-1:0]       i_radius;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [1:0]             o_visibility;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [PLANE_W-1:0]     i_cfg_data;

    logic [PLANE_W-1:0] plane_set [PLANE_COUNT];
    t_vis               vis_pending [$];
    t_vis               vis_want;
    t_row               dir_rows [$];
    int                 fail_cnt = 0;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_reqs = 0;
    int                 hold_done = 0;
    int                 hold_left = 0;
    int                 quiet_cycles = 0;

    frustum_cull_classifier u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_action     (i_action),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_point_z    (i_point_z),
        .i_far_x      (i_far_x),
        .i_far_y      (i_far_y),
        .i_far_z      (i_far_z),
        .i_radius     (i_radius),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_visibility (o_visibility),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic logic [PLANE_W-1:0] pack_plane(int nx, int ny, int nz, int d);
        logic [PF_W-1:0] sx, sy, sz, sd;
        sx = nx[PF_W-1:0];
        sy = ny[PF_W-1:0];
        sz = nz[PF_W-1:0];
        sd = d[PF_W-1:0];
        return {sd, sz, sy, sx};
    endfunction

    // plane facing into an axis-aligned slab; skew tilts the two other components
    function automatic logic [PLANE_W-1:0] axis_plane(int p, int half, int skew);
        int n [AXIS_COUNT];
        for (int a = 0; a < AXIS_COUNT; a++)
            n[a] = (skew > 0) ? int'($urandom_range(0, 2 * skew)) - skew : 0;
        n[p / 2] = (p % 2) ? -NORM_ONE : NORM_ONE;
        return pack_plane(n[0], n[1], n[2], half);
    endfunction

    function automatic logic [PF_W-1:0] extreme_slot();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [PLANE_W-1:0] rand_plane(t_plane_mode mode, int p);
        case (mode)
            PMODE_FRUSTUM:
                return axis_plane(p, $urandom_range(200, 3000), 1500);
            PMODE_RANDOM:
                return {$urandom, $urandom};
            PMODE_EXTREME:
                return {extreme_slot(), extreme_slot(), extreme_slot(), extreme_slot()};
            default:
                return $urandom_range(0, 1) ? {$urandom, $urandom}
                                            : axis_plane(p, $urandom_range(0, 4000), 4000);
        endcase
    endfunction

    function automatic longint plane_dist(int p, longint x, longint y, longint z);
        logic [PLANE_W-1:0] w;
        longint nx, ny, nz, d;
        w  = plane_set[p];
        nx = $signed(w[PF_W-1:0]);
        ny = $signed(w[2*PF_W-1:PF_W]);
        nz = $signed(w[3*PF_W-1:2*PF_W]);
        d  = $signed(w[4*PF_W-1:3*PF_W]);
        return nx * x + ny * y + nz * z + (d <<< NORMAL_FRAC_BITS);
    endfunction

    function automatic t_vis classify_volume(t_req r);
        longint lo [AXIS_COUNT];
        longint hi [AXIS_COUNT];
        longint pdist, rad, cx, cy, cz;
        int     inside_cnt, behind;
        bit     outside, any_behind, culled;
        lo[0] = $signed(r.px);
        lo[1] = $signed(r.py);
        lo[2] = $signed(r.pz);
        hi[0] = $signed(r.fx);
        hi[1] = $signed(r.fy);
        hi[2] = $signed(r.fz);
        if (r.kind == KIND_SPHERE) begin
            rad = longint'(r.radius) <<< NORMAL_FRAC_BITS;
            inside_cnt = 0;
            outside = 1'b0;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                pdist = plane_dist(p, lo[0], lo[1], lo[2]);
                if (pdist > rad)
                    inside_cnt++;
                else if (pdist < -rad)
                    outside = 1'b1;
            end
            if (outside)
                return VIS_OUTSIDE;
            return (inside_cnt == PLANE_COUNT) ? VIS_INSIDE : VIS_CROSSING;
        end
        any_behind = 1'b0;
        culled = 1'b0;
        for (int p = 0; p < PLANE_COUNT; p++) begin
            behind = 0;
            // corners as given, swapped min/max is not reordered
            for (int c = 0; c < 8; c++) begin
                cx = c[0] ? hi[0] : lo[0];
                cy = c[1] ? hi[1] : lo[1];
                cz = c[2] ? hi[2] : lo[2];
                if (plane_dist(p, cx, cy, cz) < 0)
                    behind++;
            end
            if (behind != 0)
                any_behind = 1'b1;
            if (behind == 8)
                culled = 1'b1;
        end
        if (culled)
            return VIS_OUTSIDE;
        return any_behind ? VIS_CROSSING : VIS_INSIDE;
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int   c [AXIS_COUNT];
        int   f [AXIS_COUNT];
        bit   near;
        r.kind = t_kind'($urandom_range(0, 1));
        near = ($urandom_range(0, 9) < 7);
        for (int a = 0; a < AXIS_COUNT; a++) begin
            c[a] = near ? int'($urandom_range(0, 6000)) - 3000 : int'($urandom);
            case ($urandom_range(0, 9))
                0:       f[a] = $urandom;
                1:       f[a] = c[a] - int'($urandom_range(0, 2000));
                default: f[a] = c[a] + int'($urandom_range(0, 2000));
            endcase
        end
        r.px = c[0][COORD_WIDTH-1:0];
        r.py = c[1][COORD_WIDTH-1:0];
        r.pz = c[2][COORD_WIDTH-1:0];
        r.fx = f[0][COORD_WIDTH-1:0];
        r.fy = f[1][COORD_WIDTH-1:0];
        r.fz = f[2][COORD_WIDTH-1:0];
        r.radius = RAD_W'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 1500) : $urandom);
        return r;
    endfunction

    task automatic add_row(int ph, t_kind k, int px, int py, int pz,
                           int fx, int fy, int fz, int rad, bit known, t_vis v);
        t_row row;
        row.phase      = ph;
        row.req.kind   = k;
        row.req.px     = px[COORD_WIDTH-1:0];
        row.req.py     = py[COORD_WIDTH-1:0];
        row.req.pz     = pz[COORD_WIDTH-1:0];
        row.req.fx     = fx[COORD_WIDTH-1:0];
        row.req.fy     = fy[COORD_WIDTH-1:0];
        row.req.fz     = fz[COORD_WIDTH-1:0];
        row.req.radius = rad[RAD_W-1:0];
        row.known      = known;
        row.vis        = v;
        dir_rows.push_back(row);
    endtask

    task automatic cfg_write(int idx, logic [PLANE_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx[CFG_IDX_W-1:0];
        i_cfg_data  <= data;
        @(posedge i_clk);
        if (idx < PLANE_COUNT)
            plane_set[idx] = data;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (vis_pending.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_req(t_req r, bit known, t_vis v);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_action  <= r.kind;
        i_point_x <= r.px;
        i_point_y <= r.py;
        i_point_z <= r.pz;
        i_far_x   <= r.fx;
        i_far_y   <= r.fy;
        i_far_z   <= r.fz;
        i_radius  <= r.radius;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        vis_pending.push_back(known ? v : classify_volume(r));
    endtask

    task automatic load_directed_planes(int ph);
        case (ph)
            1: for (int p = 0; p < PLANE_COUNT; p++)
                   cfg_write(p, pack_plane(0, 0, 0, 1));
            2: begin
                cfg_write(IDX_SPARE_LO, pack_plane(0, 0, 0, -1));
                cfg_write(IDX_SPARE_HI, pack_plane(0, 0, 0, -1));
            end
            3: cfg_write(3, pack_plane(0, 0, 0, -1));
            4: for (int p = 0; p < PLANE_COUNT; p++)
                   cfg_write(p, axis_plane(p, 1000, 0));
            5: for (int p = 0; p < PLANE_COUNT; p++)
                   cfg_write(p, 64'h8000_8000_8000_8000);
            default: for (int p = 0; p < PLANE_COUNT; p++)
                   cfg_write(p, 64'h7FFF_7FFF_7FFF_7FFF);
        endcase
        i_cfg_we <= 1'b0;
    endtask

    task automatic build_directed();
        // all planes zero: every distance is zero
        add_row(0, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, 1, VIS_CROSSING);
        add_row(0, KIND_SPHERE, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                1, VIS_CROSSING);
        add_row(0, KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                1, VIS_INSIDE);
        add_row(0, KIND_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 0, 1, VIS_INSIDE);
        // zero normals, d = +1: radius 1 hits the equality edge
        add_row(1, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, 1, VIS_INSIDE);
        add_row(1, KIND_SPHERE, 5, -5, 7, -1, -1, -1, 1, 1, VIS_CROSSING);
        add_row(1, KIND_SPHERE, 32767, 0, -32768, 0, 0, 0, 32767, 1, VIS_CROSSING);
        add_row(1, KIND_BOX, -100, -100, -100, 100, 100, 100, 32767, 1, VIS_INSIDE);
        // writes to spare indexes must not land
        add_row(2, KIND_SPHERE, 1, 2, 3, 0, 0, 0, 0, 1, VIS_INSIDE);
        add_row(2, KIND_BOX, 0, 0, 0, 1, 1, 1, 0, 1, VIS_INSIDE);
        // plane 3 flipped to d = -1
        add_row(3, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, 1, VIS_OUTSIDE);
        add_row(3, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 1, 1, VIS_CROSSING);
        add_row(3, KIND_BOX, -5, -5, -5, 5, 5, 5, 0, 1, VIS_OUTSIDE);
        // cube of half width 1000
        add_row(4, KIND_SPHERE, 0, 0, 0, 9999, -9999, 9999, 10, 1, VIS_INSIDE);
        add_row(4, KIND_SPHERE, 0, 0, 0, 0, 0, 0, 1000, 1, VIS_CROSSING);
        add_row(4, KIND_SPHERE, 2000, 0, 0, 0, 0, 0, 500, 1, VIS_OUTSIDE);
        add_row(4, KIND_SPHERE, 0, 0, -1500, 0, 0, 0, 500, 1, VIS_CROSSING);
        add_row(4, KIND_BOX, -10, -10, -10, 10, 10, 10, 32767, 1, VIS_INSIDE);
        add_row(4, KIND_BOX, 1500, 0, 0, 2000, 10, 10, 0, 1, VIS_OUTSIDE);
        add_row(4, KIND_BOX, -2000, -2000, -2000, 2000, 2000, 2000, 0, 1, VIS_CROSSING);
        add_row(4, KIND_BOX, 10, 10, 10, -10, -10, -10, 0, 1, VIS_INSIDE);
        add_row(4, KIND_BOX, 2000, 0, 0, 1500, 5, 5, 0, 1, VIS_OUTSIDE);
        add_row(4, KIND_BOX, 1000, 1000, 1000, -1000, -1000, -1000, 0, 1, VIS_INSIDE);
        // extreme plane words
        add_row(5, KIND_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767, 0, VIS_OUTSIDE);
        add_row(5, KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0, VIS_OUTSIDE);
        add_row(6, KIND_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0, 0, VIS_OUTSIDE);
        add_row(6, KIND_BOX, 32767, -32768, 32767, -32768, 32767, -32768, 0, 0, VIS_OUTSIDE);
    endtask

    // result side: check, then pick next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (vis_pending.size() == 0) begin
                $error("visibility: no request pending, got %0d", o_visibility);
                fail_cnt++;
            end else begin
                vis_want = vis_pending.pop_front();
                if (o_visibility !== vis_want) begin
                    $error("visibility: expected %0d, got %0d", vis_want, o_visibility);
                    fail_cnt++;
                end
            end
        end
        if (hold_reqs != hold_done) begin
            hold_done = hold_reqs;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int          cur_phase;
        int          sent;
        t_plane_mode mode;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_action    <= 1'b0;
        i_point_x   <= '0;
        i_point_y   <= '0;
        i_point_z   <= '0;
        i_far_x     <= '0;
        i_far_y     <= '0;
        i_far_z     <= '0;
        i_radius    <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        send_idle_pct = 19;
        recv_idle_pct = 59;
        for (int p = 0; p < PLANE_COUNT; p++)
            plane_set[p] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_directed();
        cur_phase = 0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].phase != cur_phase) begin
                cur_phase = dir_rows[i].phase;
                drain_results();
                load_directed_planes(cur_phase);
            end
            send_req(dir_rows[i].req, dir_rows[i].known, dir_rows[i].vis);
        end

        sent = 0;
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain_results();
            mode = t_plane_mode'(ph % 4);
            for (int p = 0; p < PLANE_COUNT; p++)
                cfg_write(p, rand_plane(mode, p));
            if ($urandom_range(0, 1))
                cfg_write($urandom_range(IDX_SPARE_LO, IDX_SPARE_HI), {$urandom, $urandom});
            i_cfg_we <= 1'b0;
            for (int k = 0; k < REQS_PER_PHASE; k++) begin
                if (sent < RAND_PHASES * REQS_PER_PHASE / 3) begin
                    send_idle_pct = 19;
                    recv_idle_pct = 59;
                end else if (sent < 2 * RAND_PHASES * REQS_PER_PHASE / 3) begin
                    send_idle_pct = 59;
                    recv_idle_pct = 19;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                // receiver backs off long enough to fill the pipe
                if ((ph == 1 || ph == 8) && k == 20)
                    hold_reqs++;
                if (ph == 5 && k == 75)
                    drain_results();
                send_req(rand_req(), 1'b0, VIS_OUTSIDE);
                sent++;
            end
        end

        drain_results();
        repeat (4 * PIPE_LATENCY) @(posedge i_clk);
        if (fail_cnt == 0 && vis_pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
